FILE: rtl/core/ecm_cwc_pkg.sv
// Package: shared types, constants and CRC helper for the control word cache.
package ecm_cwc_pkg;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned META_W = 98;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_EVICT_CHUNK = 1'b1;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_DUPLICATE = 2'd1,
    STAT_FOUND     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_PAD,
    ST_EV_RD,
    ST_EV_WR,
    ST_LK_RD,
    ST_LK_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_INS,
    ST_CP_RD,
    ST_CP_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [6:0] max_entries;
    logic [6:0] evict_chunk;
  } cfg_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/ecm_cwc_if.sv
// Interfaces: request and result channels of the control word cache.
interface ecm_cwc_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [63:0] control_word;
  logic        odd_key;

  modport source (output valid, cmd, data_byte, last_byte, control_word, odd_key,
                  input ready);
  modport sink (input valid, cmd, data_byte, last_byte, control_word, odd_key,
                output ready);
endinterface

interface ecm_cwc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] word_out;
  logic        odd_key_out;

  modport source (output valid, status, word_out, odd_key_out, input ready);
  modport sink (input valid, status, word_out, odd_key_out, output ready);
endinterface

FILE: rtl/core/ecm_cwc_ram.sv
// Generic single write port, single read port RAM with registered read.
module ecm_cwc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ecm_cwc_regs.sv
// APB configuration registers of the control word cache.
module ecm_cwc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ecm_cwc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output ecm_cwc_pkg::cfg_t            cfg_o
);
  import ecm_cwc_pkg::*;

  logic [6:0] max_entries_q, max_entries_d;
  logic [6:0] evict_chunk_q, evict_chunk_d;
  logic       wr;

  assign wr = psel && penable && pwrite;

  always_comb begin
    max_entries_d = max_entries_q;
    evict_chunk_d = evict_chunk_q;
    if (wr) begin
      unique case (paddr[2])
        REG_MAX_ENTRIES: max_entries_d = pwdata[6:0];
        REG_EVICT_CHUNK: evict_chunk_d = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= 7'd64;
      evict_chunk_q <= 7'd1;
    end else begin
      max_entries_q <= max_entries_d;
      evict_chunk_q <= evict_chunk_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_ENTRIES: prdata = {25'h0, max_entries_q};
      REG_EVICT_CHUNK: prdata = {25'h0, evict_chunk_q};
      default:         prdata = 32'h0;
    endcase
  end

  assign pready            = 1'b1;
  assign cfg_o.max_entries = max_entries_q;
  assign cfg_o.evict_chunk = evict_chunk_q;

endmodule

FILE: rtl/core/ecm_control_word_cache.sv
// Top level: hashed exact-match control word cache with first-in first-out eviction.
// Packet bytes are taken one per cycle while the cache is idle. After the last byte, missing
// bytes are padded with zeros and the hash is closed; then, for an add to a full cache,
// the oldest entries are evicted, the lookup walks the slots and compares the stored
// bytes on a hash match, and an insert copies the packet; the result register then frees
// the channel. Each step is one access of the slot metadata, age or packet memories. After
// reset a clearing pass sweeps the metadata memory before the first byte is accepted.
module ecm_control_word_cache #(
  parameter int unsigned ENTRIES      = 64,
  parameter int unsigned PACKET_BYTES = 188
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ecm_cwc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  ecm_cwc_req_if.sink                    req_i,
  ecm_cwc_res_if.source                  res_o
);
  import ecm_cwc_pkg::*;

  localparam int unsigned SW  = $clog2(ENTRIES);
  localparam int unsigned CW  = $clog2(ENTRIES + 1);
  localparam int unsigned PW  = $clog2(PACKET_BYTES);
  localparam int unsigned PCW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned AW  = $clog2(ENTRIES * PACKET_BYTES);
  localparam int unsigned LW  = (CW > 7) ? CW : 7;

  cfg_t cfg;

  ecm_cwc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  state_e         state_q, state_d;
  logic [PCW-1:0] pos_q, pos_d;
  logic [31:0]    crc_q, crc_d, hash_q, hash_d;
  logic           cmd_q, cmd_d, odd_q, odd_d;
  logic [63:0]    cw_q, cw_d;
  logic [SW-1:0]  slot_q, slot_d, free_slot_q, free_slot_d, head_q, head_d;
  logic [AW-1:0]  base_q, base_d, free_base_q, free_base_d;
  logic [PW-1:0]  idx_q, idx_d;
  logic           free_q, free_d;
  logic [CW-1:0]  count_q, count_d;
  logic [6:0]     evn_q, evn_d;
  status_e        rstat_q, rstat_d, ostat_q, ostat_d;
  logic [63:0]    rword_q, rword_d, oword_q, oword_d;
  logic           rodd_q, rodd_d, oodd_q, oodd_d, ov_q, ov_d;

  logic              inc_we, pkt_we, meta_we, age_we;
  logic [7:0]        inc_wdata, inc_rdata, pkt_rdata;
  logic [AW-1:0]     pkt_waddr, pkt_raddr;
  logic [SW-1:0]     meta_waddr, age_waddr, age_rdata;
  logic [META_W-1:0] meta_wdata, meta_rdata;

  logic          acc, in_room;
  logic [LW-1:0] lim, me_w;
  logic [6:0]    ch;
  logic          full;
  logic [SW:0]   tail_sum;
  logic [SW-1:0] tail;

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid && (state_q == ST_IDLE);
  assign in_room     = pos_q < PCW'(PACKET_BYTES);

  assign me_w = LW'(cfg.max_entries);
  assign lim  = (cfg.max_entries == 7'd0) ? LW'(1) :
                ((me_w > LW'(ENTRIES)) ? LW'(ENTRIES) : me_w);
  assign ch   = (cfg.evict_chunk == 7'd0) ? 7'd1 : cfg.evict_chunk;
  assign full = (LW'(count_q) >= lim) && (count_q != '0);

  assign tail_sum = (SW+1)'(head_q) + (SW+1)'(count_q);
  assign tail     = (tail_sum >= (SW+1)'(ENTRIES)) ? SW'(tail_sum - (SW+1)'(ENTRIES))
                                                   : SW'(tail_sum);

  ecm_cwc_ram #(.Width(8), .Depth(PACKET_BYTES)) u_inc_ram (
    .clk_i, .we_i(inc_we), .waddr_i(pos_q[PW-1:0]), .wdata_i(inc_wdata),
    .raddr_i(idx_q), .rdata_o(inc_rdata)
  );

  ecm_cwc_ram #(.Width(8), .Depth(ENTRIES * PACKET_BYTES)) u_pkt_ram (
    .clk_i, .we_i(pkt_we), .waddr_i(pkt_waddr), .wdata_i(inc_rdata),
    .raddr_i(pkt_raddr), .rdata_o(pkt_rdata)
  );

  ecm_cwc_ram #(.Width(META_W), .Depth(ENTRIES)) u_meta_ram (
    .clk_i, .we_i(meta_we), .waddr_i(meta_waddr), .wdata_i(meta_wdata),
    .raddr_i(slot_q), .rdata_o(meta_rdata)
  );

  ecm_cwc_ram #(.Width(SW), .Depth(ENTRIES)) u_age_ram (
    .clk_i, .we_i(age_we), .waddr_i(age_waddr), .wdata_i(free_slot_q),
    .raddr_i(head_q), .rdata_o(age_rdata)
  );

  // memory control
  always_comb begin
    inc_we     = (acc && in_room) || ((state_q == ST_PAD) && in_room);
    inc_wdata  = (state_q == ST_IDLE) ? req_i.data_byte : 8'h00;
    pkt_we     = (state_q == ST_CP_WR);
    pkt_waddr  = free_base_q + AW'(idx_q);
    pkt_raddr  = base_q + AW'(idx_q);
    age_we     = (state_q == ST_INS);
    age_waddr  = tail;
    meta_we    = 1'b0;
    meta_waddr = slot_q;
    meta_wdata = '0;
    unique case (state_q)
      ST_CLR: meta_we = 1'b1;
      ST_EV_WR: begin
        meta_we    = 1'b1;
        meta_waddr = age_rdata;
      end
      ST_INS: begin
        meta_we    = 1'b1;
        meta_waddr = free_slot_q;
        meta_wdata = {1'b1, odd_q, cw_q, hash_q};
      end
      default: ;
    endcase
  end

  // next state and datapath
  always_comb begin
    logic adv, fnd, setup;
    adv = 1'b0;
    fnd = free_q;
    setup = 1'b0;
    state_d = state_q;
    pos_d = pos_q;
    crc_d = crc_q;
    hash_d = hash_q;
    cmd_d = cmd_q;
    odd_d = odd_q;
    cw_d = cw_q;
    slot_d = slot_q;
    free_slot_d = free_slot_q;
    head_d = head_q;
    base_d = base_q;
    free_base_d = free_base_q;
    idx_d = idx_q;
    free_d = free_q;
    count_d = count_q;
    evn_d = evn_q;
    rstat_d = rstat_q;
    rword_d = rword_q;
    rodd_d = rodd_q;
    ostat_d = ostat_q;
    oword_d = oword_q;
    oodd_d = oodd_q;
    ov_d = ov_q && !res_o.ready;

    unique case (state_q)
      ST_CLR: begin
        slot_d = slot_q + 1'b1;
        if (slot_q == SW'(ENTRIES - 1)) begin
          slot_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          if (in_room) begin
            crc_d = crc_byte(crc_q, req_i.data_byte);
            pos_d = pos_q + 1'b1;
          end
          if (req_i.last_byte) begin
            cmd_d   = req_i.cmd;
            cw_d    = req_i.control_word;
            odd_d   = req_i.odd_key;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (in_room) begin
          crc_d = crc_byte(crc_q, 8'h00);
          pos_d = pos_q + 1'b1;
        end else begin
          hash_d = crc_q;
          crc_d  = CRC_INIT;
          pos_d  = '0;
          if (cmd_q == CMD_ADD && full) begin
            evn_d   = '0;
            state_d = ST_EV_RD;
          end else begin
            setup = 1'b1;
          end
        end
      end
      ST_EV_RD: state_d = ST_EV_WR;
      ST_EV_WR: begin
        head_d  = (head_q == SW'(ENTRIES - 1)) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
        evn_d   = evn_q + 7'd1;
        if ((evn_q + 7'd1) < ch && count_q != CW'(1)) begin
          state_d = ST_EV_RD;
        end else begin
          setup = 1'b1;
        end
      end
      ST_LK_RD: state_d = ST_LK_CHK;
      ST_LK_CHK: begin
        if (meta_rdata[97] && meta_rdata[31:0] == hash_q) begin
          rword_d = meta_rdata[95:32];
          rodd_d  = meta_rdata[96];
          idx_d   = '0;
          state_d = ST_CMP_RD;
        end else begin
          if (!meta_rdata[97] && !free_q) begin
            fnd         = 1'b1;
            free_d      = 1'b1;
            free_slot_d = slot_q;
            free_base_d = base_q;
          end
          adv = 1'b1;
        end
      end
      ST_CMP_RD: state_d = ST_CMP_CHK;
      ST_CMP_CHK: begin
        if (pkt_rdata != inc_rdata) begin
          adv = 1'b1;
        end else if (idx_q == PW'(PACKET_BYTES - 1)) begin
          if (cmd_q == CMD_FIND) begin
            rstat_d = STAT_FOUND;
          end else begin
            rstat_d = STAT_DUPLICATE;
            rword_d = '0;
            rodd_d  = 1'b0;
          end
          state_d = ST_RESP;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CMP_RD;
        end
      end
      ST_INS: begin
        count_d = count_q + 1'b1;
        idx_d   = '0;
        state_d = ST_CP_RD;
      end
      ST_CP_RD: state_d = ST_CP_WR;
      ST_CP_WR: begin
        if (idx_q == PW'(PACKET_BYTES - 1)) begin
          rstat_d = STAT_INSERTED;
          rword_d = '0;
          rodd_d  = 1'b0;
          state_d = ST_RESP;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CP_RD;
        end
      end
      ST_RESP: begin
        if (!ov_q || res_o.ready) begin
          ov_d    = 1'b1;
          ostat_d = rstat_q;
          oword_d = rword_q;
          oodd_d  = rodd_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (setup) begin
      slot_d  = '0;
      base_d  = '0;
      free_d  = 1'b0;
      state_d = ST_LK_RD;
    end

    if (adv) begin
      if (slot_q == SW'(ENTRIES - 1)) begin
        rword_d = '0;
        rodd_d  = 1'b0;
        if (cmd_q == CMD_FIND) begin
          rstat_d = STAT_NOT_FOUND;
          state_d = ST_RESP;
        end else if (fnd) begin
          state_d = ST_INS;
        end else begin
          rstat_d = STAT_DUPLICATE;
          state_d = ST_RESP;
        end
      end else begin
        slot_d  = slot_q + 1'b1;
        base_d  = base_q + AW'(PACKET_BYTES);
        state_d = ST_LK_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      pos_q   <= '0;
      crc_q   <= CRC_INIT;
      slot_q  <= '0;
      head_q  <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      slot_q  <= slot_d;
      head_q  <= head_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q      <= hash_d;
    cmd_q       <= cmd_d;
    odd_q       <= odd_d;
    cw_q        <= cw_d;
    free_slot_q <= free_slot_d;
    base_q      <= base_d;
    free_base_q <= free_base_d;
    idx_q       <= idx_d;
    free_q      <= free_d;
    evn_q       <= evn_d;
    rstat_q     <= rstat_d;
    rword_q     <= rword_d;
    rodd_q      <= rodd_d;
    ostat_q     <= ostat_d;
    oword_q     <= oword_d;
    oodd_q      <= oodd_d;
  end

  assign res_o.valid       = ov_q;
  assign res_o.status      = ostat_q;
  assign res_o.word_out    = oword_q;
  assign res_o.odd_key_out = oodd_q;

endmodule

FILE: sim/tb.sv
// Testbench for the control word cache: directed and random key packets checked against a scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecm_cwc_pkg::*;

  localparam int SLOTS = 64;
  localparam int PKT_LEN = 188;
  localparam int MAX_LEN = 196;
  localparam int POOL = 32;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1300;

  typedef struct {
    status_e     status;
    logic [63:0] word;
    logic        odd;
  } lookup_result_t;

  class cw_cache_scoreboard;
    logic [6:0]  max_entries;
    logic [6:0]  evict_chunk;
    logic [7:0]  rx_pkt[PKT_LEN];
    int          rx_pos;
    logic [31:0] rx_crc;
    logic [7:0]  slot_pkt[SLOTS][PKT_LEN];
    logic [31:0] slot_hash[SLOTS];
    logic [63:0] slot_word[SLOTS];
    logic        slot_odd[SLOTS];
    bit          slot_used[SLOTS];
    logic [5:0]  age_q[SLOTS];
    logic [5:0]  head;
    int          count;
    lookup_result_t expected_q[$];
    int          errors;

    function new();
      max_entries = 7'd64;
      evict_chunk = 7'd1;
      rx_pos = 0;
      rx_crc = '1;
      head = '0;
      count = 0;
      errors = 0;
      foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      c ^= {b, 24'h0};
      for (int k = 0; k < 8; k++) c = c[31] ? ({c[30:0], 1'b0} ^ 32'h04C11DB7) : {c[30:0], 1'b0};
      return c;
    endfunction

    function void take_byte(logic [7:0] b);
      rx_pkt[rx_pos] = b;
      rx_crc = crc_next(rx_crc, b);
      rx_pos++;
    endfunction

    function int match_slot(logic [31:0] h);
      bit same;
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_used[s] && slot_hash[s] == h) begin
          same = 1;
          for (int j = 0; j < PKT_LEN; j++) if (slot_pkt[s][j] != rx_pkt[j]) same = 0;
          if (same) return s;
        end
      end
      return -1;
    endfunction

    function void note_request(logic cmd, logic [7:0] b, logic last, logic [63:0] cw, logic odd);
      lookup_result_t r;
      logic [31:0] h;
      int lim, chunk, hit, s;
      if (rx_pos < PKT_LEN) take_byte(b);
      if (!last) return;
      while (rx_pos < PKT_LEN) take_byte(8'h00);
      h = rx_crc;
      rx_pos = 0;
      rx_crc = '1;
      r.word = '0;
      r.odd = 1'b0;
      if (cmd == CMD_FIND) begin
        hit = match_slot(h);
        if (hit >= 0) begin
          r.status = STAT_FOUND;
          r.word = slot_word[hit];
          r.odd = slot_odd[hit];
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end else begin
        lim = (max_entries == 0) ? 1 : (max_entries > SLOTS ? SLOTS : max_entries);
        chunk = (evict_chunk == 0) ? 1 : evict_chunk;
        if (count >= lim) begin
          for (int i = 0; i < chunk && count > 0; i++) begin
            slot_used[age_q[head]] = 0;
            head++;
            count--;
          end
        end
        if (match_slot(h) >= 0) begin
          r.status = STAT_DUPLICATE;
        end else begin
          s = 0;
          while (s < SLOTS && slot_used[s]) s++;
          for (int j = 0; j < PKT_LEN; j++) slot_pkt[s][j] = rx_pkt[j];
          slot_hash[s] = h;
          slot_word[s] = cw;
          slot_odd[s] = odd;
          slot_used[s] = 1;
          age_q[6'(head + count)] = 6'(s);
          count++;
          r.status = STAT_INSERTED;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [63:0] word, logic odd);
      lookup_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: status %0d word %h odd %0d", $time, status, word, odd);
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (status != e.status || word != e.word || odd != e.odd) begin
        $display("%0t mismatch: expected status %0d word %h odd %0d,", $time, e.status, e.word,
                 e.odd, " actual status %0d word %h odd %0d", status, word, odd);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ecm_cwc_req_if req ();
  ecm_cwc_res_if res ();

  ecm_control_word_cache DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_i(req), .res_o(res)
  );

  cw_cache_scoreboard sb = new();
  bit quiet = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  logic [7:0] pool_pkt[POOL][MAX_LEN];
  int pool_len[POOL];
  int pool_n = 0;
  logic [7:0] cur_pkt[MAX_LEN];
  int cur_len;

  always #6 clk_i = ~clk_i;

  initial begin
    req.valid = 1'b0;
    req.cmd = 1'b0;
    req.data_byte = '0;
    req.last_byte = 1'b0;
    req.control_word = '0;
    req.odd_key = 1'b0;
    res.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (res.valid && res.ready) sb.check_result(res.status, res.word_out, res.odd_key_out);
    if ((req.valid && req.ready) || (res.valid && res.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    int hold;
    gap = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off && hold == 0) begin
        hold = 400;
        hold_off = 0;
      end
      if (hold > 0) begin
        hold--;
        res.ready = 1'b0;
      end else if (gap > 0) begin
        gap--;
        res.ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(0, 13);
        res.ready = 1'b0;
      end else begin
        res.ready = 1'b1;
      end
    end
  end

  task automatic reg_write(logic idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_MAX_ENTRIES) sb.max_entries = value[6:0];
    else sb.evict_chunk = value[6:0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_byte(logic cmd, logic [7:0] b, logic last, logic [63:0] cw, logic odd);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    req.valid = 1'b1;
    req.cmd = cmd;
    req.data_byte = b;
    req.last_byte = last;
    req.control_word = cw;
    req.odd_key = odd;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(cmd, b, last, cw, odd);
    @(negedge clk_i);
  endtask

  task automatic send_packet(logic cmd, logic [63:0] cw, logic odd);
    for (int i = 0; i < cur_len; i++) begin
      send_byte((i == cur_len - 1) ? cmd : logic'($urandom_range(0, 1)), cur_pkt[i],
                i == cur_len - 1, cw, odd);
    end
    req.valid = 1'b0;
  endtask

  task automatic directed(logic cmd, int len, logic [7:0] b0, logic [7:0] b1, logic [63:0] cw,
                          logic odd);
    cur_len = len;
    cur_pkt[0] = b0;
    cur_pkt[1] = b1;
    for (int i = 2; i < len; i++) cur_pkt[i] = 8'(i * 7);
    send_packet(cmd, cw, odd);
  endtask

  task automatic random_packet(int add_pct);
    int r;
    int p;
    logic cmd;
    cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_FIND;
    if (pool_n > 0 && $urandom_range(0, 99) < (cmd == CMD_FIND ? 70 : 35)) begin
      p = $urandom_range(0, pool_n - 1);
      cur_len = pool_len[p];
      for (int i = 0; i < cur_len; i++) cur_pkt[i] = pool_pkt[p][i];
      if (cur_len > PKT_LEN) for (int i = PKT_LEN; i < cur_len; i++) cur_pkt[i] = 8'($urandom);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 99) begin
        cur_len = $urandom_range(1, 6);
      end else begin
        r = $urandom_range(0, 2);
        if (r == 0) cur_len = PKT_LEN;
        else if (r == 1) cur_len = $urandom_range(PKT_LEN + 1, MAX_LEN);
        else cur_len = $urandom_range(7, 40);
      end
      for (int i = 0; i < cur_len; i++) cur_pkt[i] = 8'($urandom);
      if (pool_n < POOL) begin
        p = pool_n;
        pool_n++;
      end else begin
        p = $urandom_range(0, POOL - 1);
      end
      pool_len[p] = cur_len;
      for (int i = 0; i < cur_len; i++) pool_pkt[p][i] = cur_pkt[i];
    end
    send_packet(cmd, {$urandom, $urandom}, logic'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  initial begin
    int phase_max[7] = '{64, 4, 1, 0, 127, 8, 2};
    int phase_chunk[7] = '{1, 3, 1, 0, 127, 64, 2};
    int phase_pkts[7] = '{80, 25, 20, 20, 25, 20, 25};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    reg_write(REG_MAX_ENTRIES, 32'd64);
    reg_write(REG_EVICT_CHUNK, 32'd1);
    directed(CMD_ADD, 1, 8'h00, 8'h00, '1, 1'b1);
    directed(CMD_FIND, 1, 8'h00, 8'h00, '0, 1'b0);
    directed(CMD_FIND, 1, 8'hFF, 8'h00, '0, 1'b0);
    directed(CMD_ADD, 1, 8'h00, 8'h00, '0, 1'b0);
    // trailing zero bytes pad to the same key
    directed(CMD_ADD, 2, 8'h00, 8'h00, 64'h1234, 1'b1);
    directed(CMD_ADD, 2, 8'hFF, 8'h80, '0, 1'b0);
    directed(CMD_FIND, 2, 8'hFF, 8'h80, '1, 1'b1);
    directed(CMD_FIND, 2, 8'hFF, 8'h7F, '1, 1'b1);
    // full-length key, then the same key with extra bytes that are dropped
    directed(CMD_ADD, PKT_LEN, 8'h47, 8'h1F, 64'hA5A5_0000_FFFF_0001, 1'b1);
    directed(CMD_FIND, MAX_LEN, 8'h47, 8'h1F, '0, 1'b0);

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      reg_write(REG_MAX_ENTRIES, phase_max[ph]);
      reg_write(REG_EVICT_CHUNK, phase_chunk[ph]);
      if (ph == 6) quiet = 1;
      for (int k = 0; k < phase_pkts[ph]; k++) begin
        if (ph == 1 && k == 2) hold_off = 1;
        random_packet(ph == 0 ? 80 : 55);
      end
    end

    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

FILE: files.f
rtl/core/ecm_cwc_pkg.sv
rtl/core/ecm_cwc_if.sv
rtl/core/ecm_cwc_ram.sv
rtl/core/ecm_cwc_regs.sv
rtl/core/ecm_control_word_cache.sv
sim/tb.sv
